### rtl/pscm_pkg.sv
// ----------------------------------------------------------------------------
// pscm_pkg: shared constants for the parity stripe column map
// Field widths, register indexes and fixed address constants.
// ----------------------------------------------------------------------------
package pscm_pkg;

	localparam int SECTOR_SHIFT = 9;
	localparam int MAX_COLUMNS  = 16;
	localparam int SWAP_BIT     = 20;

	localparam int OFFSET_W = 56;
	localparam int LENGTH_W = 25;
	localparam int SECT_W   = OFFSET_W - SECTOR_SHIFT;
	localparam int NSECT_W  = LENGTH_W - SECTOR_SHIFT;
	localparam int CFG_W    = 5;
	localparam int NP_W     = 2;
	localparam int COL_W    = 4;
	localparam int ADDR_W   = 57;
	localparam int BYTES_W  = 25;
	localparam int ASECT_W  = ADDR_W - SECTOR_SHIFT;

	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 96;

	// label gap of 0x400000 bytes, counted in sectors
	localparam logic [ASECT_W-1:0] LABEL_GAP_SECT = ASECT_W'(32'h0040_0000 >> SECTOR_SHIFT);

	localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = CFG_W'(3);
	localparam logic [NP_W-1:0]  PARITY_COUNT_RESET = NP_W'(1);

	typedef enum logic {
		REG_COLUMN_COUNT = 1'b0,
		REG_PARITY_COUNT = 1'b1
	} reg_index_t;

endpackage

### rtl/parity_stripe_column_map.sv
// ----------------------------------------------------------------------------
// parity_stripe_column_map: logical read request to stripe column results
// Splits a read request into sectors and emits one result per stripe column.
// ----------------------------------------------------------------------------
// One request is in flight at a time. After an item is accepted the sector
// number is divided by column_count and the sector count by the number of
// data columns in two restoring dividers that retire one quotient bit per
// cycle; the sector number divider steps through each bit of the sector
// number, and the sector count divider runs alongside it in the final steps.
// ST_PREP then sets up the column sizes and addresses, ST_LOAD registers the
// first column result, and then one column result leaves per cycle while the
// output side takes them. A request is dropped on acceptance when the group
// shape is unusable, or after the division when it maps to no column.
module parity_stripe_column_map (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 wr_en,
	input  logic                                 wr_index,
	input  logic [pscm_pkg::CFG_W-1:0]           wr_data,
	// request
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// byte_offset[55:0], byte_length[80:56], zero fill above
	input  logic [pscm_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// column results
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// column_index[3:0], device_index[7:4], device_address[64:8],
	// column_bytes[89:65], zero fill above
	output logic [pscm_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// is_parity[0]
	output logic                                 m_axis_tuser,
	output logic                                 m_axis_tlast
);

	localparam int CW     = pscm_pkg::CFG_W;
	localparam int SW     = pscm_pkg::SECT_W;
	localparam int NW     = pscm_pkg::NSECT_W;
	localparam int AW     = pscm_pkg::ASECT_W;
	localparam int SS     = pscm_pkg::SECTOR_SHIFT;
	localparam int CNT_W  = $clog2(SW);
	localparam int RES_W  = 2 * pscm_pkg::COL_W + pscm_pkg::ADDR_W + pscm_pkg::BYTES_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_PREP,
		ST_LOAD,
		ST_EMIT
	} state_t;

	state_t                     state_q;
	logic [CW-1:0]              column_count_q;
	logic [pscm_pkg::NP_W-1:0]  parity_count_q;

	logic [CNT_W-1:0]           cnt_q;
	logic [SW-1:0]              sect_q;
	logic [CW-1:0]              rem1_q;
	logic [NW-1:0]              nsect_q;
	logic [CW-1:0]              rem2_q;
	logic                       swap_bit_q;
	logic                       swap_q;
	logic [AW-1:0]              addr_lo_q;
	logic [AW-1:0]              addr_hi_q;
	logic [NW-1:0]              q_q;
	logic [NW-1:0]              qp1_q;
	logic [CW-1:0]              bc_q;
	logic [CW-1:0]              acols_q;
	logic [CW-1:0]              scols_q;
	logic [CW-1:0]              col_q;
	logic [RES_W-1:0]           res_q;
	logic                       last_q;
	logic                       valid_q;

	// divider steps
	logic [CW:0]   rem1_sh, rem2_sh;
	logic          ge1, ge2;
	logic [CW-1:0] rem1_nx, rem2_nx;
	logic [CW-1:0] dcnt;
	logic          cfg_bad;

	// setup of the column map
	logic [CW-1:0] bc, v, rnd, scols, acols;
	logic [9:0]    v11;

	// result for one column
	logic [CW-1:0]             idx, eidx;
	logic [CW:0]               sum;
	logic                      wrap;
	logic [CW:0]               dev;
	logic [pscm_pkg::BYTES_W-1:0] bytes;
	logic [RES_W-1:0]          res;
	logic                      res_last;

	assign dcnt    = column_count_q - CW'(parity_count_q);
	assign cfg_bad = (CW'(parity_count_q) >= column_count_q)
		|| (int'(column_count_q) > pscm_pkg::MAX_COLUMNS);

	always_comb begin
		rem1_sh = {rem1_q, sect_q[SW-1]};
		ge1     = rem1_sh >= {1'b0, column_count_q};
		rem1_nx = ge1 ? CW'(rem1_sh - {1'b0, column_count_q}) : CW'(rem1_sh);
		rem2_sh = {rem2_q, nsect_q[NW-1]};
		ge2     = rem2_sh >= {1'b0, dcnt};
		rem2_nx = ge2 ? CW'(rem2_sh - {1'b0, dcnt}) : CW'(rem2_sh);
	end

	always_comb begin
		bc  = (rem2_q == '0) ? '0 : rem2_q + CW'(parity_count_q);
		v   = bc + CW'(parity_count_q);
		// v * 11 / 32 is v / 3 for every v below 32
		v11 = 10'(v) * 10'd11;
		unique case (parity_count_q)
			2'd0: rnd = bc;
			2'd1: rnd = {v[CW-1:1], 1'b0};
			2'd2: rnd = v11[9:5] + {v11[8:5], 1'b0};
			2'd3: rnd = {v[CW-1:2], 2'b00};
			default: rnd = bc;
		endcase
		if (nsect_q == '0) begin
			acols = bc;
			scols = (rnd < column_count_q) ? rnd : column_count_q;
		end else begin
			acols = column_count_q;
			scols = column_count_q;
		end
	end

	// result for column idx; with the swap, columns 0 and 1 trade place
	always_comb begin
		idx  = (state_q == ST_EMIT) ? col_q + CW'(1) : '0;
		eidx = (swap_q && idx < CW'(2)) ? {idx[CW-1:1], ~idx[0]} : idx;
		sum  = {1'b0, rem1_q} + {1'b0, eidx};
		wrap = sum >= {1'b0, column_count_q};
		dev  = wrap ? sum - {1'b0, column_count_q} : sum;
		if (idx >= acols_q) begin
			bytes = '0;
		end else if (idx < bc_q) begin
			bytes = {qp1_q, SS'(0)};
		end else begin
			bytes = {q_q, SS'(0)};
		end
		res = {
			(idx < CW'(parity_count_q)),
			bytes,
			wrap ? addr_hi_q : addr_lo_q, SS'(0),
			dev[pscm_pkg::COL_W-1:0],
			idx[pscm_pkg::COL_W-1:0]
		};
		res_last = (idx + CW'(1)) == scols_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			column_count_q <= pscm_pkg::COLUMN_COUNT_RESET;
			parity_count_q <= pscm_pkg::PARITY_COUNT_RESET;
			valid_q        <= 1'b0;
			last_q         <= 1'b0;
			cnt_q          <= '0;
			col_q          <= '0;
		end else begin
			if (wr_en) begin
				unique case (pscm_pkg::reg_index_t'(wr_index))
					pscm_pkg::REG_COLUMN_COUNT: column_count_q <= wr_data;
					pscm_pkg::REG_PARITY_COUNT: parity_count_q <= wr_data[pscm_pkg::NP_W-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						sect_q     <= s_axis_tdata[pscm_pkg::OFFSET_W-1:SS];
						nsect_q    <= s_axis_tdata[pscm_pkg::OFFSET_W+pscm_pkg::LENGTH_W-1:
							pscm_pkg::OFFSET_W+SS];
						swap_bit_q <= s_axis_tdata[pscm_pkg::SWAP_BIT];
						rem1_q     <= '0;
						rem2_q     <= '0;
						cnt_q      <= CNT_W'(SW - 1);
						// drop the item when the group shape is unusable
						if (!cfg_bad) begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					sect_q <= {sect_q[SW-2:0], ge1};
					rem1_q <= rem1_nx;
					if (int'(cnt_q) < NW) begin
						nsect_q <= {nsect_q[NW-2:0], ge2};
						rem2_q  <= rem2_nx;
					end
					cnt_q <= cnt_q - CNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					addr_lo_q <= {1'b0, sect_q} + pscm_pkg::LABEL_GAP_SECT;
					addr_hi_q <= {1'b0, sect_q} + pscm_pkg::LABEL_GAP_SECT + AW'(1);
					q_q       <= nsect_q;
					qp1_q     <= nsect_q + NW'(1);
					bc_q      <= bc;
					acols_q   <= acols;
					scols_q   <= scols;
					swap_q    <= swap_bit_q && (parity_count_q == 2'd1) && (scols >= CW'(2));
					state_q   <= (scols == '0) ? ST_IDLE : ST_LOAD;
				end
				ST_LOAD: begin
					res_q   <= res;
					last_q  <= res_last;
					valid_q <= 1'b1;
					col_q   <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (m_axis_tready) begin
						if (last_q) begin
							valid_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							// advance to the next column without a gap
							res_q  <= res;
							last_q <= res_last;
							col_q  <= col_q + CW'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign s_axis_tready = (state_q == ST_IDLE);
	assign m_axis_tvalid = valid_q;
	assign m_axis_tlast  = last_q;
	assign m_axis_tuser  = res_q[RES_W-1];
	assign m_axis_tdata  = {(pscm_pkg::OUT_TDATA_W - RES_W + 1)'(0), res_q[RES_W-2:0]};

`ifndef SYNTHESIS
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid))
		else $error("request accepted while results pending");

	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not ready after final column");

	a_quiet_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid)
		else $error("result before division finished");

	a_column_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
		m_axis_tvalid && (m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1))
		else $error("column results out of order");
`endif

endmodule
